FILE: sv/slc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Types, character constants and the special-word step function shared by
// the scalar literal classifier modules.
// ----------------------------------------------------------------------------
package slc_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_INT    = 3'd1,
    KIND_FLOAT  = 3'd2,
    KIND_DOUBLE = 3'd3,
    KIND_NONE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_INT    = 2'd0,
    PH_FRAC   = 2'd1,
    PH_SUFFIX = 2'd2,
    PH_DEAD   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    W_NONE = 4'd0,
    W_I    = 4'd1,
    W_IN   = 4'd2,
    W_INF  = 4'd3,
    W_INFF = 4'd4,
    W_N    = 4'd5,
    W_NA   = 4'd6,
    W_NAN  = 4'd7,
    W_NANF = 4'd8,
    W_DEAD = 4'd15
  } word_t;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;

  localparam logic [2:0] POS_MAX = 3'd7;

  // Classification handed from the front end to the queue
  typedef struct packed {
    logic  push;
    kind_t kind;
  } slc_push_t;

  // Queue status used for the input ready and by the output stage
  typedef struct packed {
    logic  full;
    logic  empty;
    kind_t head;
  } slc_qstat_t;

  function automatic word_t word_next(input word_t w, input logic [7:0] c);
    word_t r;
    r = W_DEAD;
    unique case (w)
      W_NONE: r = (c == CH_I) ? W_I : ((c == CH_N) ? W_N : W_DEAD);
      W_I:    r = (c == CH_N) ? W_IN : W_DEAD;
      W_IN:   r = (c == CH_F) ? W_INF : W_DEAD;
      W_INF:  r = (c == CH_F) ? W_INFF : W_DEAD;
      W_N:    r = (c == CH_A) ? W_NA : W_DEAD;
      W_NA:   r = (c == CH_N) ? W_NAN : W_DEAD;
      W_NAN:  r = (c == CH_F) ? W_NANF : W_DEAD;
      default: r = W_DEAD;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/slc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_front
// Runs the recognizers on each accepted byte and emits the literal type
// when the final byte of a literal is accepted.
// ----------------------------------------------------------------------------
module slc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [7:0]          character,
  input  logic                last,
  output slc_pkg::slc_push_t  push
);

  logic [2:0]       pos_r, pos_nxt;
  logic             quote_r, quote_nxt;
  logic             digits_r, digits_nxt;
  slc_pkg::phase_t  fph_r, fph_nxt;
  slc_pkg::phase_t  dph_r, dph_nxt;
  slc_pkg::word_t   word_r, word_nxt;

  logic             dig;
  logic             is_sign;
  logic             body;
  slc_pkg::phase_t  fph_step, dph_step;
  slc_pkg::kind_t   kind;

  assign dig     = (character >= slc_pkg::CH_ZERO) && (character <= slc_pkg::CH_NINE);
  assign is_sign = (pos_r == 3'd0) &&
                   ((character == slc_pkg::CH_PLUS) || (character == slc_pkg::CH_MINUS));
  assign body    = !is_sign;

  always_comb begin
    unique case (fph_r)
      slc_pkg::PH_INT:
        fph_step = dig ? slc_pkg::PH_INT :
                   (character == slc_pkg::CH_POINT) ? slc_pkg::PH_FRAC :
                   (character == slc_pkg::CH_F) ? slc_pkg::PH_SUFFIX : slc_pkg::PH_DEAD;
      slc_pkg::PH_FRAC:
        fph_step = dig ? slc_pkg::PH_FRAC :
                   (character == slc_pkg::CH_F) ? slc_pkg::PH_SUFFIX : slc_pkg::PH_DEAD;
      default:
        fph_step = slc_pkg::PH_DEAD;
    endcase

    unique case (dph_r)
      slc_pkg::PH_INT:
        dph_step = dig ? slc_pkg::PH_INT :
                   (character == slc_pkg::CH_POINT) ? slc_pkg::PH_FRAC : slc_pkg::PH_DEAD;
      slc_pkg::PH_FRAC:
        dph_step = dig ? slc_pkg::PH_FRAC : slc_pkg::PH_DEAD;
      default:
        dph_step = slc_pkg::PH_DEAD;
    endcase
  end

  always_comb begin
    if (pos_r == 3'd0) begin
      quote_nxt = (character == slc_pkg::CH_QUOTE);
    end else if ((pos_r == 3'd2) && (character != slc_pkg::CH_QUOTE)) begin
      quote_nxt = 1'b0;
    end else begin
      quote_nxt = quote_r;
    end
    digits_nxt = (body && !dig) ? 1'b0 : digits_r;
    fph_nxt    = body ? fph_step : fph_r;
    dph_nxt    = body ? dph_step : dph_r;
    word_nxt   = body ? slc_pkg::word_next(word_r, character) : word_r;
    pos_nxt    = (pos_r == slc_pkg::POS_MAX) ? pos_r : pos_r + 3'd1;

    // priority order: char, int, float, double
    if ((pos_r == 3'd2) && quote_nxt) begin
      kind = slc_pkg::KIND_CHAR;
    end else if (digits_nxt) begin
      kind = slc_pkg::KIND_INT;
    end else if ((word_nxt == slc_pkg::W_INFF) || (word_nxt == slc_pkg::W_NANF) ||
                 (fph_nxt == slc_pkg::PH_SUFFIX)) begin
      kind = slc_pkg::KIND_FLOAT;
    end else if ((word_nxt == slc_pkg::W_INF) || (word_nxt == slc_pkg::W_NAN) ||
                 (dph_nxt == slc_pkg::PH_FRAC)) begin
      kind = slc_pkg::KIND_DOUBLE;
    end else begin
      kind = slc_pkg::KIND_NONE;
    end
  end

  assign push.push = in_accept && last;
  assign push.kind = kind;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && last)) begin
      pos_r    <= 3'd0;
      quote_r  <= 1'b0;
      digits_r <= 1'b1;
      fph_r    <= slc_pkg::PH_INT;
      dph_r    <= slc_pkg::PH_INT;
      word_r   <= slc_pkg::W_NONE;
    end else if (in_accept) begin
      pos_r    <= pos_nxt;
      quote_r  <= quote_nxt;
      digits_r <= digits_nxt;
      fph_r    <= fph_nxt;
      dph_r    <= dph_nxt;
      word_r   <= word_nxt;
    end
  end

endmodule

FILE: sv/slc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_queue
// Two-entry queue of literal types between the classifier front end and
// the output stage.
// ----------------------------------------------------------------------------
module slc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  slc_pkg::slc_push_t  push,
  input  logic                pop,
  output slc_pkg::slc_qstat_t stat
);

  slc_pkg::kind_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign do_push = push.push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/slc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_back
// Output register: takes the head of the queue and holds it on the result
// channel until the consumer accepts it.
// ----------------------------------------------------------------------------
module slc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  slc_pkg::slc_qstat_t stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata
);

  logic           valid_r;
  slc_pkg::kind_t kind_r;

  // refill when empty or when the held item leaves this cycle
  assign pop = !stat.empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= stat.head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, kind_r};

endmodule

FILE: sv/scalar_literal_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_literal_classifier_core
// Classifies a scalar literal streamed one byte per item.
// ----------------------------------------------------------------------------
// One byte is taken every clock while in_tready is high; in_tready drops only
// when the two-entry result queue is full. The final byte of a literal
// (in_tlast) produces one result, the literal type (0 char, 1 int, 2 float,
// 3 double, 4 none). When the output side is free, the result passes through
// the queue entry and then the output register before it shows on
// out_tdata. Other bytes produce no result. The recognizer state clears
// itself after each final byte, so literals may follow each other with no gap.
module scalar_literal_classifier_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] literal_type, [7:3] zero
);

  slc_pkg::slc_push_t  push;
  slc_pkg::slc_qstat_t stat;
  logic                pop;
  logic                in_accept;

  assign in_tready = !stat.full;
  assign in_accept = in_tvalid && in_tready;

  slc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .character (in_tdata),
    .last      (in_tlast),
    .push      (push)
  );

  slc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  slc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/slc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks for the scalar literal classifier.
// ----------------------------------------------------------------------------
module slc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("result or stall present after reset");

  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] == 5'd0) && (out_tdata[2:0] <= 3'd4))
    else $error("literal type out of range");

  // with no result shown and no final byte taken last edge or this one,
  // nothing is queued, so no result may show next
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !$past(in_tvalid && in_tready && in_tlast) &&
     !(in_tvalid && in_tready && in_tlast)) |=> !out_tvalid)
    else $error("result without a final byte");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind scalar_literal_classifier_core slc_checker u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
